FILE: hdl/lcar_pkg.sv
// ----------------------------------------------------------------------------
// Load-cell reader package
// Shared widths, payload and configuration types, sequencer control word
// format and the microcode program.
// ----------------------------------------------------------------------------
package lcar_pkg;

    // Converter word and run sizes
    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_READINGS = 64;
    localparam int CNT_W        = $clog2(MAX_READINGS + 1);
    localparam int ACC_W        = SAMPLE_BITS + $clog2(MAX_READINGS);
    localparam int BIT_W        = $clog2(SAMPLE_BITS + 1);
    localparam int DIV_CNT_W    = $clog2(ACC_W + 1);
    localparam int TICK_W       = 20;

    // Scaling arithmetic
    localparam int COEFF_W  = 32;
    localparam int WEIGHT_W = 32;
    localparam int HALF_W   = COEFF_W / 2;
    localparam int FRAC_W   = 16;
    localparam int MUL_W    = SAMPLE_BITS + HALF_W;
    localparam int PROD_W   = SAMPLE_BITS + COEFF_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGH_N  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_N   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_GAP = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF    = CFG_IDX_W'(4);

    localparam logic [TICK_W-1:0]         RST_TIMEOUT  = TICK_W'(200000);
    localparam logic [CNT_W-1:0]          RST_WEIGH_N  = CNT_W'(10);
    localparam logic [CNT_W-1:0]          RST_TARE_N   = CNT_W'(5);
    localparam logic [TICK_W-1:0]         RST_TARE_GAP = TICK_W'(20000);
    localparam logic signed [COEFF_W-1:0] RST_COEFF    = COEFF_W'(65536000);

    // Command codes carried on each tick
    localparam logic [1:0] FUNC_WEIGH = 2'd1;
    localparam logic [1:0] FUNC_TARE  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic       dt_level;
    } t_in_item;

    typedef struct packed {
        logic                       sck_level;
        logic                       busy_res;
        logic                       done_res;
        logic signed [WEIGHT_W-1:0] weight_mg;
        logic [SAMPLE_BITS-1:0]     raw_average;
        logic [SAMPLE_BITS-1:0]     tare_value;
        logic [CNT_W-1:0]           timeout_count;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0]         timeout_ticks;
        logic [CNT_W-1:0]          weigh_samples;
        logic [CNT_W-1:0]          tare_samples;
        logic [TICK_W-1:0]         tare_gap_ticks;
        logic signed [COEFF_W-1:0] scale_coeff;
    } t_cfg;

    // Microcode
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TICK,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_AVG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ADD,
        OP_SAT,
        OP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ITEM,
        C_NOT_FINAL,
        C_DIV_MORE,
        C_TARE,
        C_OUT_READY
    } t_ucond;

    typedef struct packed {
        t_uop            op;
        t_ucond          cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_uop op;
        logic fire;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic final_rd;
        logic div_more;
        logic run_tare;
    } t_status;

    localparam logic [PC_W-1:0] ST_FETCH    = PC_W'(0);
    localparam logic [PC_W-1:0] ST_DIV_STEP = PC_W'(3);
    localparam logic [PC_W-1:0] ST_EMIT     = PC_W'(9);

    // Program: fetch a tick, update the reader; on the last reading of a run
    // divide serially, then store the tare or scale the weight; emit result.
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_W'(0):  w = '{op: OP_TICK,     cond: C_NO_ITEM,   target: ST_FETCH};
            PC_W'(1):  w = '{op: OP_NOP,      cond: C_NOT_FINAL, target: ST_EMIT};
            PC_W'(2):  w = '{op: OP_DIV_INIT, cond: C_NONE,      target: ST_FETCH};
            PC_W'(3):  w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: ST_DIV_STEP};
            PC_W'(4):  w = '{op: OP_AVG,      cond: C_TARE,      target: ST_EMIT};
            PC_W'(5):  w = '{op: OP_MUL_LO,   cond: C_NONE,      target: ST_FETCH};
            PC_W'(6):  w = '{op: OP_MUL_HI,   cond: C_NONE,      target: ST_FETCH};
            PC_W'(7):  w = '{op: OP_ADD,      cond: C_NONE,      target: ST_FETCH};
            PC_W'(8):  w = '{op: OP_SAT,      cond: C_NONE,      target: ST_FETCH};
            PC_W'(9):  w = '{op: OP_EMIT,     cond: C_OUT_READY, target: ST_FETCH};
            PC_W'(10): w = '{op: OP_NOP,      cond: C_ALWAYS,    target: ST_EMIT};
            default:   w = '{op: OP_NOP,      cond: C_ALWAYS,    target: ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/lcar_cfg.sv
// ----------------------------------------------------------------------------
// Load-cell reader configuration registers
// Plain write-only register bank with reset defaults.
// ----------------------------------------------------------------------------
module lcar_cfg
    import lcar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks  <= RST_TIMEOUT;
            r_cfg.weigh_samples  <= RST_WEIGH_N;
            r_cfg.tare_samples   <= RST_TARE_N;
            r_cfg.tare_gap_ticks <= RST_TARE_GAP;
            r_cfg.scale_coeff    <= RST_COEFF;
        end else if (i_we) begin
            case (i_idx)
                CFG_TIMEOUT:  r_cfg.timeout_ticks  <= i_data[TICK_W-1:0];
                CFG_WEIGH_N:  r_cfg.weigh_samples  <= i_data[CNT_W-1:0];
                CFG_TARE_N:   r_cfg.tare_samples   <= i_data[CNT_W-1:0];
                CFG_TARE_GAP: r_cfg.tare_gap_ticks <= i_data[TICK_W-1:0];
                CFG_COEFF:    r_cfg.scale_coeff    <= $signed(i_data[COEFF_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/lcar_useq.sv
// ----------------------------------------------------------------------------
// Load-cell reader microcode sequencer
// Step counter, program lookup and conditional jumps.
// ----------------------------------------------------------------------------
module lcar_useq
    import lcar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_in_stall
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            take;

    assign uw = uc_rom(r_pc);

    always_comb begin
        case (uw.cond)
            C_NONE:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ITEM:   take = !i_in_valid;
            C_NOT_FINAL: take = !i_status.final_rd;
            C_DIV_MORE:  take = i_status.div_more;
            C_TARE:      take = i_status.run_tare;
            C_OUT_READY: take = i_out_ready;
            default:     take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Tick runs only on a transfer, emit only into a free output slot
    always_comb begin
        o_ctrl.op = uw.op;
        case (uw.op)
            OP_TICK: o_ctrl.fire = i_in_valid;
            OP_EMIT: o_ctrl.fire = i_out_ready;
            default: o_ctrl.fire = 1'b1;
        endcase
    end

    assign o_in_stall = (uw.op != OP_TICK);

endmodule

FILE: hdl/lcar_dpath.sv
// ----------------------------------------------------------------------------
// Load-cell reader datapath
// Per-tick reader update, serial divider, shared multiplier and saturation.
// ----------------------------------------------------------------------------
module lcar_dpath
    import lcar_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl     i_ctrl,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_status   o_status,
    output t_out_item o_item
);

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WAIT  = 7'b0000010,
        PH_HIGH  = 7'b0000100,
        PH_LOW   = 7'b0001000,
        PH_XHIGH = 7'b0010000,
        PH_XLOW  = 7'b0100000,
        PH_GAP   = 7'b1000000
    } t_phase;

    localparam logic [SAMPLE_BITS-1:0] TOP_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int MAG_W = PROD_W - FRAC_W;

    // Reader state
    t_phase                     r_phase, n_phase;
    logic                       r_run_tare, n_run_tare;
    logic [TICK_W-1:0]          r_tick, n_tick;
    logic [BIT_W-1:0]           r_bit, n_bit;
    logic [SAMPLE_BITS-1:0]     r_shift, n_shift;
    logic [CNT_W-1:0]           r_rc, n_rc;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic [CNT_W-1:0]           r_tout, n_tout;
    logic                       r_final, n_final;
    logic [SAMPLE_BITS-1:0]     r_tare;
    logic [SAMPLE_BITS-1:0]     r_avg;
    logic signed [WEIGHT_W-1:0] r_weight;

    // Working registers
    logic [CNT_W-1:0]       r_div_n;
    logic [ACC_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_rem;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [SAMPLE_BITS-1:0] r_dmag;
    logic                   r_dneg;
    logic [COEFF_W-1:0]     r_cmag;
    logic                   r_cneg;
    logic [MUL_W-1:0]       r_pp;
    logic [PROD_W-1:0]      r_prod;

    logic [CNT_W-1:0]       n_raw, eff_n, rc_inc;
    logic [TICK_W:0]        tick_inc;
    logic [BIT_W-1:0]       bit_inc;
    logic                   fin_en;
    logic [SAMPLE_BITS-1:0] fin_val;

    // Readings per run: zero acts as one, large counts clamp
    always_comb begin
        n_raw = r_run_tare ? i_cfg.tare_samples : i_cfg.weigh_samples;
        if (n_raw == '0) begin
            eff_n = CNT_W'(1);
        end else if (n_raw > CNT_W'(MAX_READINGS)) begin
            eff_n = CNT_W'(MAX_READINGS);
        end else begin
            eff_n = n_raw;
        end
    end

    assign tick_inc = {1'b0, r_tick} + (TICK_W + 1)'(1);
    assign bit_inc  = r_bit + BIT_W'(1);
    assign rc_inc   = r_rc + CNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_run_tare = r_run_tare;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_rc       = r_rc;
        n_acc      = r_acc;
        n_tout     = r_tout;
        n_final    = 1'b0;
        fin_en     = 1'b0;
        fin_val    = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.func == FUNC_WEIGH || i_item.func == FUNC_TARE) begin
                    n_run_tare = (i_item.func == FUNC_TARE);
                    n_rc       = '0;
                    n_acc      = '0;
                    n_tout     = '0;
                    n_tick     = '0;
                    n_phase    = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!i_item.dt_level) begin
                    n_bit   = '0;
                    n_shift = '0;
                    n_phase = PH_HIGH;
                end else begin
                    n_tick = tick_inc[TICK_W-1:0];
                    if (tick_inc >= {1'b0, i_cfg.timeout_ticks}) begin
                        n_tout = r_tout + CNT_W'(1);
                        fin_en = 1'b1;
                    end
                end
            end
            PH_HIGH: begin
                n_shift = {r_shift[SAMPLE_BITS-2:0], 1'b0};
                n_phase = PH_LOW;
            end
            PH_LOW: begin
                n_shift = {r_shift[SAMPLE_BITS-1:1], r_shift[0] | i_item.dt_level};
                n_bit   = bit_inc;
                n_phase = (bit_inc >= BIT_W'(SAMPLE_BITS)) ? PH_XHIGH : PH_HIGH;
            end
            PH_XHIGH: begin
                n_phase = PH_XLOW;
            end
            PH_XLOW: begin
                fin_en  = 1'b1;
                fin_val = r_shift ^ TOP_BIT;
            end
            PH_GAP: begin
                if (tick_inc >= {1'b0, i_cfg.tare_gap_ticks}) begin
                    n_tick  = '0;
                    n_phase = PH_WAIT;
                end else begin
                    n_tick = tick_inc[TICK_W-1:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Close a reading: accumulate, count, then finish the run or go on
        if (fin_en) begin
            n_acc  = r_acc + ACC_W'(fin_val);
            n_rc   = rc_inc;
            n_tick = '0;
            if (rc_inc >= eff_n) begin
                n_final = 1'b1;
                n_phase = PH_IDLE;
            end else if (r_run_tare && i_cfg.tare_gap_ticks != '0) begin
                n_phase = PH_GAP;
            end else begin
                n_phase = PH_WAIT;
            end
        end
    end

    // Restoring divider step
    logic [CNT_W-1:0] rem_sh;
    logic             div_ge;

    assign rem_sh = {r_rem[CNT_W-2:0], r_quo[ACC_W-1]};
    assign div_ge = (rem_sh >= r_div_n);

    // Difference to tare and coefficient as sign and magnitude
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS:0]   diff_w;
    logic [SAMPLE_BITS:0]   diff_neg_w;
    logic [COEFF_W-1:0]     coeff_u;

    assign avg        = r_quo[SAMPLE_BITS-1:0];
    assign diff_w     = {1'b0, avg} - {1'b0, r_tare};
    assign diff_neg_w = (SAMPLE_BITS + 1)'(0) - diff_w;
    assign coeff_u    = $unsigned(i_cfg.scale_coeff);

    // One shared multiplier, low coefficient half first
    logic [HALF_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_out;

    assign mul_b   = (i_ctrl.op == OP_MUL_HI) ? r_cmag[COEFF_W-1:HALF_W] : r_cmag[HALF_W-1:0];
    assign mul_out = MUL_W'(r_dmag) * MUL_W'(mul_b);

    // Truncate toward zero on the magnitude, then saturate
    logic [MAG_W-1:0]           mag;
    logic                       p_neg, p_over;
    logic signed [WEIGHT_W-1:0] sat_val;

    assign mag    = r_prod[PROD_W-1:FRAC_W];
    assign p_neg  = r_dneg ^ r_cneg;
    assign p_over = |mag[MAG_W-1:WEIGHT_W-1];

    always_comb begin
        if (p_over) begin
            sat_val = p_neg ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else if (p_neg) begin
            sat_val = $signed(WEIGHT_W'(0) - mag[WEIGHT_W-1:0]);
        end else begin
            sat_val = $signed(mag[WEIGHT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_run_tare <= 1'b0;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_rc       <= '0;
            r_acc      <= '0;
            r_tout     <= '0;
            r_final    <= 1'b0;
            r_tare     <= '0;
            r_avg      <= '0;
            r_weight   <= '0;
        end else if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_TICK: begin
                    r_phase    <= n_phase;
                    r_run_tare <= n_run_tare;
                    r_tick     <= n_tick;
                    r_bit      <= n_bit;
                    r_shift    <= n_shift;
                    r_rc       <= n_rc;
                    r_acc      <= n_acc;
                    r_tout     <= n_tout;
                    r_final    <= n_final;
                end
                OP_AVG: begin
                    r_avg <= avg;
                    if (r_run_tare) begin
                        r_tare <= avg;
                    end
                end
                OP_SAT: begin
                    r_weight <= sat_val;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_TICK: begin
                    r_div_n <= eff_n;
                end
                OP_DIV_INIT: begin
                    r_quo     <= r_acc;
                    r_rem     <= '0;
                    r_div_cnt <= DIV_CNT_W'(ACC_W);
                end
                OP_DIV_STEP: begin
                    r_rem     <= div_ge ? rem_sh - r_div_n : rem_sh;
                    r_quo     <= {r_quo[ACC_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                end
                OP_AVG: begin
                    r_dneg <= diff_w[SAMPLE_BITS];
                    r_dmag <= diff_w[SAMPLE_BITS] ? diff_neg_w[SAMPLE_BITS-1:0]
                                                  : diff_w[SAMPLE_BITS-1:0];
                    r_cneg <= coeff_u[COEFF_W-1];
                    r_cmag <= coeff_u[COEFF_W-1] ? COEFF_W'(0) - coeff_u : coeff_u;
                end
                OP_MUL_LO: begin
                    r_pp <= mul_out;
                end
                OP_MUL_HI: begin
                    r_prod <= PROD_W'(r_pp);
                    r_pp   <= mul_out;
                end
                OP_ADD: begin
                    r_prod <= r_prod + PROD_W'({r_pp, {HALF_W{1'b0}}});
                end
                default: ;
            endcase
        end
    end

    assign o_status.final_rd = r_final;
    assign o_status.div_more = (r_div_cnt != DIV_CNT_W'(1));
    assign o_status.run_tare = r_run_tare;

    assign o_item.sck_level     = (r_phase == PH_HIGH) || (r_phase == PH_XHIGH);
    assign o_item.busy_res      = (r_phase != PH_IDLE);
    assign o_item.done_res      = r_final;
    assign o_item.weight_mg     = r_weight;
    assign o_item.raw_average   = r_avg;
    assign o_item.tare_value    = r_tare;
    assign o_item.timeout_count = r_tout;

endmodule

FILE: hdl/load_cell_adc_reader_with_tare.sv
// ----------------------------------------------------------------------------
// Load-cell converter reader with tare
// Bit-bangs a two-wire 24-bit load-cell converter, averages readings and
// keeps a tare; weighs in milligrams through a signed Q16.16 coefficient.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per
//    microsecond tick, carrying the sampled data pin level and a command
//    (start weighing, start taring, or plain tick; commands while busy drop).
//  - Output channel (o_out_valid / i_out_stall / o_out_data): exactly one
//    result per tick, holding the clock pin level to drive and the status.
//  - Config port (i_cfg_we / i_cfg_idx / i_cfg_data): write only while no
//    tick is in flight; indexes beyond the register list are ignored.
//  - Timing: a microcoded sequencer takes each tick through a short program.
//    An ordinary tick runs a tick, a check and an emit step. The tick that
//    closes a run adds a 30-step serial divide (one quotient bit a cycle),
//    then an average step for a tare run, and for a weighing also a
//    two-pass 24x16 multiply, an add and a saturate step.
//  - One tick is worked on at a time; the next is taken while the previous
//    result still sits in the output register.
//  - Reset (synchronous, active low) returns the reader to idle, clears the
//    tare, last weight and average, and loads the register defaults.
//  - A stalled receiver holds the result; the sequencer waits at its emit
//    step and takes no new tick until the output register frees up.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare
    import lcar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_ctrl     ctrl;
    t_status   status;
    t_out_item dp_item;

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      out_ready;
    logic      emit;

    // Output slot is free when empty or being drained this cycle
    assign out_ready = !r_out_valid || !i_out_stall;
    assign emit      = ctrl.fire && (ctrl.op == OP_EMIT);

    lcar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lcar_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (out_ready),
        .i_status    (status),
        .o_ctrl      (ctrl),
        .o_in_stall  (o_in_stall)
    );

    lcar_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_status (status),
        .o_item   (dp_item)
    );

    // Output register: load on emit, drop valid once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload holds while stalled; only emit writes it
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= dp_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
